// ===== rtl/clfs_pkg.sv =====
// ----------------------------------------------------------------------------
// clfs_pkg
// shared types, widths and constants of the loop current to flow scaler
// ----------------------------------------------------------------------------
package clfs_pkg;

	localparam int CUR_W  = 10;
	localparam int FLOW_W = 16;
	localparam int PCT_W  = 14;
	localparam int TGT_W  = 30;
	localparam int PER_W  = 18;

	// current clamp for the percentage modes, 0.1 mA units
	localparam int CURRENT_FULL_SCALE = 200;
	localparam logic [CUR_W-1:0] FULL_SCALE_CUR = CUR_W'(CURRENT_FULL_SCALE);
	localparam logic [CUR_W-1:0] LIVE_ZERO_CUR  = CUR_W'(40);

	localparam int PCT_RAW_W = 17;
	localparam logic [PCT_RAW_W-1:0] PCT_MAX     = PCT_RAW_W'(10000);
	localparam logic [PCT_RAW_W-1:0] GAIN_0_20   = PCT_RAW_W'(50);
	// (x * 625) / 10 is (x * 125) >> 1
	localparam logic [PCT_RAW_W-1:0] GAIN_4_20   = PCT_RAW_W'(625 / 5);
	localparam int                   GAIN_4_20_SH = 1;

	// interpolation numerator and divider
	localparam int DQ_W          = 20;
	localparam int NUM_W         = 30;
	localparam int REM_W         = CUR_W;
	localparam int DIV_BITS      = 20;
	localparam int DIV_PER_STAGE = 4;
	localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

	// divide by 3600 = shift by 4, then multiply by reciprocal of 225
	localparam int PER_PRE_SH   = 4;
	localparam int PER_RECIP_SH = 34;
	localparam int PER_RECIP_W  = 27;
	localparam int PER_PROD_W   = TGT_W - PER_PRE_SH + PER_RECIP_W;
	localparam logic [PER_RECIP_W-1:0] PER_RECIP = PER_RECIP_W'(76354975);

	localparam logic [31:0] HI_SCALE = 32'd10000;
	localparam logic [31:0] LO_SCALE = 32'd1000;

	// register map, word index
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_LO_CUR  = 3'd1;
	localparam logic [2:0] REG_LO_FLOW = 3'd2;
	localparam logic [2:0] REG_HI_CUR  = 3'd3;
	localparam logic [2:0] REG_HI_FLOW = 3'd4;
	localparam logic [2:0] REG_RATED   = 3'd5;

	typedef enum logic [1:0] {
		MODE_PCT_0_20 = 2'd0,
		MODE_PCT_4_20 = 2'd1,
		MODE_RISE     = 2'd2,
		MODE_FALL     = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [CUR_W-1:0]  lo_cur;
		logic [FLOW_W-1:0] lo_flow;
		logic [CUR_W-1:0]  hi_cur;
		logic [FLOW_W-1:0] hi_flow;
		logic [FLOW_W-1:0] rated;
	} cfg_t;

	// per-sample facts carried alongside the divider
	typedef struct packed {
		logic [PCT_W-1:0] pct;
		logic [TGT_W-1:0] pt;
		logic             lt;
		logic             zero;
		logic             above;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [DIV_BITS-1:0] w;
		logic [CUR_W-1:0]    den;
	} div_t;

	// result word, percent in the lowest bits
	typedef struct packed {
		logic             fault;
		logic             pause;
		logic             per_vld;
		logic [PER_W-1:0] period;
		logic [TGT_W-1:0] target;
		logic [PCT_W-1:0] pct;
	} res_t;

endpackage

// ===== rtl/clfs_regs.sv =====
// ----------------------------------------------------------------------------
// clfs_regs
// apb register file for mode and calibration settings
// ----------------------------------------------------------------------------
module clfs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [clfs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output clfs_pkg::cfg_t               cfg
);

	logic [2:0] idx;
	logic       wr;
	clfs_pkg::cfg_t cfg_q;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= clfs_pkg::MODE_PCT_4_20;
			cfg_q.lo_cur  <= clfs_pkg::CUR_W'(40);
			cfg_q.lo_flow <= '0;
			cfg_q.hi_cur  <= clfs_pkg::CUR_W'(200);
			cfg_q.hi_flow <= '0;
			cfg_q.rated   <= '0;
		end else if (wr) begin
			unique case (idx)
				clfs_pkg::REG_MODE:    cfg_q.mode    <= clfs_pkg::mode_t'(pwdata[1:0]);
				clfs_pkg::REG_LO_CUR:  cfg_q.lo_cur  <= pwdata[clfs_pkg::CUR_W-1:0];
				clfs_pkg::REG_LO_FLOW: cfg_q.lo_flow <= pwdata[clfs_pkg::FLOW_W-1:0];
				clfs_pkg::REG_HI_CUR:  cfg_q.hi_cur  <= pwdata[clfs_pkg::CUR_W-1:0];
				clfs_pkg::REG_HI_FLOW: cfg_q.hi_flow <= pwdata[clfs_pkg::FLOW_W-1:0];
				clfs_pkg::REG_RATED:   cfg_q.rated   <= pwdata[clfs_pkg::FLOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			clfs_pkg::REG_MODE:    prdata = 32'(cfg_q.mode);
			clfs_pkg::REG_LO_CUR:  prdata = 32'(cfg_q.lo_cur);
			clfs_pkg::REG_LO_FLOW: prdata = 32'(cfg_q.lo_flow);
			clfs_pkg::REG_HI_CUR:  prdata = 32'(cfg_q.hi_cur);
			clfs_pkg::REG_HI_FLOW: prdata = 32'(cfg_q.hi_flow);
			clfs_pkg::REG_RATED:   prdata = 32'(cfg_q.rated);
			default:               prdata = '0;
		endcase
	end

endmodule

// ===== rtl/clfs_front.sv =====
// ----------------------------------------------------------------------------
// clfs_front
// two pipeline stages: clamp and percent, then products and divider setup
// ----------------------------------------------------------------------------
module clfs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	output logic                       in_rdy,
	input  logic [clfs_pkg::CUR_W-1:0] cur,
	input  clfs_pkg::cfg_t             cfg,
	output logic                       out_vld,
	input  logic                       out_rdy,
	output clfs_pkg::side_t            side,
	output clfs_pkg::div_t             dv
);

	logic en_s1, en_s2;
	logic vld_s1, vld_s2;

	logic [clfs_pkg::CUR_W-1:0]     c_hi, c_lo;
	logic [clfs_pkg::PCT_RAW_W-1:0] p0, p1, praw;
	logic [clfs_pkg::PCT_W-1:0]     pct;
	logic [clfs_pkg::FLOW_W-1:0]    dq;
	logic [clfs_pkg::DQ_W-1:0]      dqx;

	logic [clfs_pkg::PCT_W-1:0] pct_s1;
	logic [clfs_pkg::CUR_W-1:0] di_s1, den_s1;
	logic [clfs_pkg::DQ_W-1:0]  dqx_s1;
	logic                       lt_s1, zero_s1, above_s1;

	logic [clfs_pkg::NUM_W:0]   num_w;
	logic [clfs_pkg::NUM_W-1:0] num;
	logic [clfs_pkg::TGT_W-1:0] pt;

	clfs_pkg::side_t side_s2;
	clfs_pkg::div_t  dv_s2;

	assign en_s2   = !vld_s2 | out_rdy;
	assign en_s1   = !vld_s1 | en_s2;
	assign in_rdy  = en_s1;
	assign out_vld = vld_s2;
	assign side    = side_s2;
	assign dv      = dv_s2;

	always_comb begin
		c_hi = (cur > clfs_pkg::FULL_SCALE_CUR) ? clfs_pkg::FULL_SCALE_CUR : cur;
		c_lo = (c_hi < clfs_pkg::LIVE_ZERO_CUR) ? clfs_pkg::LIVE_ZERO_CUR : c_hi;
		p0   = clfs_pkg::PCT_RAW_W'(c_hi) * clfs_pkg::GAIN_0_20;
		p1   = (clfs_pkg::PCT_RAW_W'(c_lo - clfs_pkg::LIVE_ZERO_CUR) * clfs_pkg::GAIN_4_20)
			>> clfs_pkg::GAIN_4_20_SH;
		unique case (cfg.mode)
			clfs_pkg::MODE_PCT_0_20: praw = p0;
			clfs_pkg::MODE_PCT_4_20: praw = p1;
			default:                 praw = '0;
		endcase
		pct = (praw > clfs_pkg::PCT_MAX) ? clfs_pkg::PCT_MAX[clfs_pkg::PCT_W-1:0]
			: praw[clfs_pkg::PCT_W-1:0];
		dq  = (cfg.mode == clfs_pkg::MODE_RISE) ? cfg.hi_flow - cfg.lo_flow
			: cfg.lo_flow - cfg.hi_flow;
		dqx = (clfs_pkg::DQ_W'(dq) << 3) + (clfs_pkg::DQ_W'(dq) << 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_vld) begin
			pct_s1   <= pct;
			di_s1    <= cur - cfg.lo_cur;
			den_s1   <= cfg.hi_cur - cfg.lo_cur;
			dqx_s1   <= dqx;
			lt_s1    <= cur < cfg.lo_cur;
			zero_s1  <= (cur == '0) && (cfg.lo_cur == '0) && (cfg.lo_flow == '0);
			above_s1 <= cur >= cfg.hi_cur;
		end
	end

	// numerator carries half the divisor for round to nearest
	always_comb begin
		num_w = clfs_pkg::NUM_W'(di_s1) * clfs_pkg::NUM_W'(dqx_s1)
			+ (clfs_pkg::NUM_W + 1)'(den_s1 >> 1);
		num   = num_w[clfs_pkg::NUM_W-1:0];
		pt    = clfs_pkg::TGT_W'(pct_s1) * clfs_pkg::TGT_W'(cfg.rated);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			side_s2.pct   <= pct_s1;
			side_s2.pt    <= pt;
			side_s2.lt    <= lt_s1;
			side_s2.zero  <= zero_s1;
			side_s2.above <= above_s1;
			dv_s2.rem     <= num[clfs_pkg::NUM_W-1:clfs_pkg::DIV_BITS];
			dv_s2.w       <= num[clfs_pkg::DIV_BITS-1:0];
			dv_s2.den     <= den_s1;
		end
	end

endmodule

// ===== rtl/clfs_div_stage.sv =====
// ----------------------------------------------------------------------------
// clfs_div_stage
// one registered slice of the restoring divider, a few quotient bits each
// ----------------------------------------------------------------------------
module clfs_div_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	output logic            in_rdy,
	input  clfs_pkg::side_t side_in,
	input  clfs_pkg::div_t  dv_in,
	output logic            out_vld,
	input  logic            out_rdy,
	output clfs_pkg::side_t side_out,
	output clfs_pkg::div_t  dv_out
);

	logic en;
	logic vld_s1;
	clfs_pkg::side_t side_s1;
	clfs_pkg::div_t  dv_s1;

	logic [clfs_pkg::REM_W-1:0]    r;
	logic [clfs_pkg::REM_W:0]      t;
	logic [clfs_pkg::DIV_BITS-1:0] w;
	logic                          qb;

	assign en       = !vld_s1 | out_rdy;
	assign in_rdy   = en;
	assign out_vld  = vld_s1;
	assign side_out = side_s1;
	assign dv_out   = dv_s1;

	// dividend bits shift out the top, quotient bits shift in the bottom
	always_comb begin
		r  = dv_in.rem;
		w  = dv_in.w;
		t  = '0;
		qb = 1'b0;
		for (int k = 0; k < clfs_pkg::DIV_PER_STAGE; k++) begin
			t  = {r, w[clfs_pkg::DIV_BITS-1]};
			qb = t >= {1'b0, dv_in.den};
			if (qb) begin
				t = t - {1'b0, dv_in.den};
			end
			r = t[clfs_pkg::REM_W-1:0];
			w = {w[clfs_pkg::DIV_BITS-2:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_vld) begin
			side_s1    <= side_in;
			dv_s1.rem  <= r;
			dv_s1.w    <= w;
			dv_s1.den  <= dv_in.den;
		end
	end

endmodule

// ===== rtl/clfs_back.sv =====
// ----------------------------------------------------------------------------
// clfs_back
// two pipeline stages: interpolation sum and period, then mode select
// ----------------------------------------------------------------------------
module clfs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	output logic                          in_rdy,
	input  clfs_pkg::side_t               side_in,
	input  logic [clfs_pkg::DIV_BITS-1:0] quot,
	input  clfs_pkg::cfg_t                cfg,
	output logic                          out_vld,
	input  logic                          out_rdy,
	output clfs_pkg::res_t                res
);

	logic en_s1, en_s2;
	logic vld_s1, vld_s2;

	logic [clfs_pkg::DQ_W-1:0]       lo_x10, base;
	logic [clfs_pkg::PER_PROD_W-1:0] per_prod;

	clfs_pkg::side_t             side_s1;
	logic [clfs_pkg::DQ_W-1:0]   base_s1;
	logic [clfs_pkg::PER_W-1:0]  period_s1;

	logic fault_rise, fault_fall;
	logic [clfs_pkg::TGT_W-1:0] hi_tgt, mid_tgt;
	clfs_pkg::res_t r;
	clfs_pkg::res_t res_s2;

	assign en_s2   = !vld_s2 | out_rdy;
	assign en_s1   = !vld_s1 | en_s2;
	assign in_rdy  = en_s1;
	assign out_vld = vld_s2;
	assign res     = res_s2;

	always_comb begin
		lo_x10   = (clfs_pkg::DQ_W'(cfg.lo_flow) << 3) + (clfs_pkg::DQ_W'(cfg.lo_flow) << 1);
		base     = (cfg.mode == clfs_pkg::MODE_RISE) ? lo_x10 + quot : lo_x10 - quot;
		per_prod = clfs_pkg::PER_PROD_W'(side_in.pt >> clfs_pkg::PER_PRE_SH)
			* clfs_pkg::PER_PROD_W'(clfs_pkg::PER_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_vld) begin
			side_s1   <= side_in;
			base_s1   <= base;
			period_s1 <= per_prod[clfs_pkg::PER_RECIP_SH+clfs_pkg::PER_W-1:
				clfs_pkg::PER_RECIP_SH];
		end
	end

	always_comb begin
		fault_rise = (cfg.hi_cur <= cfg.lo_cur) || (cfg.hi_flow < cfg.lo_flow);
		fault_fall = (cfg.hi_cur <= cfg.lo_cur) || (cfg.lo_flow < cfg.hi_flow);
		hi_tgt     = clfs_pkg::TGT_W'(32'(cfg.hi_flow) * clfs_pkg::HI_SCALE);
		mid_tgt    = clfs_pkg::TGT_W'(32'(base_s1) * clfs_pkg::LO_SCALE);
		r          = '0;
		unique case (cfg.mode)
			clfs_pkg::MODE_PCT_0_20, clfs_pkg::MODE_PCT_4_20: begin
				r.pct     = side_s1.pct;
				r.target  = side_s1.pt;
				r.period  = period_s1;
				r.per_vld = 1'b1;
				r.pause   = side_s1.pct == '0;
			end
			clfs_pkg::MODE_RISE: begin
				if (fault_rise) begin
					r.fault = 1'b1;
					r.pause = 1'b1;
				end else if (side_s1.lt || side_s1.zero) begin
					r.pause = 1'b1;
				end else if (side_s1.above) begin
					r.target = hi_tgt;
				end else begin
					r.target = mid_tgt;
				end
			end
			clfs_pkg::MODE_FALL: begin
				// zero flow means the pump is paused
				if (fault_fall) begin
					r.fault = 1'b1;
					r.pause = 1'b1;
				end else if (side_s1.lt) begin
					r.pause = 1'b1;
				end else if (side_s1.above) begin
					r.target = hi_tgt;
					r.pause  = cfg.hi_flow == '0;
				end else begin
					r.target = mid_tgt;
					r.pause  = base_s1 == '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			res_s2 <= r;
		end
	end

endmodule

// ===== rtl/current_loop_to_flow_scaler.sv =====
// ----------------------------------------------------------------------------
// current_loop_to_flow_scaler
// loop current sample to pump target flow, four scaling modes
// ----------------------------------------------------------------------------
// Takes one loop current word per cycle while s_tready is high and returns
// one result word per sample, in order. The pipeline is two front stages
// (clamp and percent, then the rated-flow and interpolation products), five
// divider stages that each settle four quotient bits of the rounded
// interpolation step, and two back stages (interpolation sum with the
// divide by 3600, then mode select into the output register). Every stage
// has its own valid bit and moves whenever the stage after it is free, so
// bubbles close up under back pressure and new samples keep entering while
// a finished result waits on m_tready. Settings are written over the apb
// port and must only change while no sample is in flight.
module current_loop_to_flow_scaler (
	input  logic        clk,
	input  logic        arst_n,

	// sample input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] loop_current

	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	// [13:0] percent, [43:14] target_flow, [61:44] period_flow,
	// [62] period_flow_valid, [63] pause, [64] calibration_fault
	output logic [71:0] m_tdata,

	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	clfs_pkg::cfg_t cfg;

	// divider chain links, index 0 is the front output
	logic            dvld [0:clfs_pkg::DIV_STAGES];
	logic            drdy [0:clfs_pkg::DIV_STAGES];
	clfs_pkg::side_t dside[0:clfs_pkg::DIV_STAGES];
	clfs_pkg::div_t  ddv  [0:clfs_pkg::DIV_STAGES];

	clfs_pkg::res_t res;

	clfs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	clfs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (s_tvalid),
		.in_rdy  (s_tready),
		.cur     (s_tdata[clfs_pkg::CUR_W-1:0]),
		.cfg     (cfg),
		.out_vld (dvld[0]),
		.out_rdy (drdy[0]),
		.side    (dside[0]),
		.dv      (ddv[0])
	);

	// rounded division of the interpolation numerator
	for (genvar g = 0; g < clfs_pkg::DIV_STAGES; g++) begin : g_div
		clfs_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (dvld[g]),
			.in_rdy   (drdy[g]),
			.side_in  (dside[g]),
			.dv_in    (ddv[g]),
			.out_vld  (dvld[g+1]),
			.out_rdy  (drdy[g+1]),
			.side_out (dside[g+1]),
			.dv_out   (ddv[g+1])
		);
	end

	clfs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (dvld[clfs_pkg::DIV_STAGES]),
		.in_rdy  (drdy[clfs_pkg::DIV_STAGES]),
		.side_in (dside[clfs_pkg::DIV_STAGES]),
		.quot    (ddv[clfs_pkg::DIV_STAGES].w),
		.cfg     (cfg),
		.out_vld (m_tvalid),
		.out_rdy (m_tready),
		.res     (res)
	);

	// result word padded to whole bytes
	assign m_tdata = {(72 - $bits(clfs_pkg::res_t))'(0), res};

endmodule

// ===== tb/current_loop_to_flow_scaler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_loop_to_flow_scaler_test
// self-checking bench for the loop current to flow scaler
// ----------------------------------------------------------------------------
// Loop current words go in on the s_ side with random gaps. Result words are
// taken on the m_ side with random stalls and one long hold-off that backs
// the pipeline up into the input. Every accepted sample is run through a
// local model of the four scaling modes. Each result word is checked field by
// field against the oldest pending prediction. Settings change over the apb
// port only while nothing is in flight: first a directed sweep of each mode
// and its corner cases, then many random settings with random currents.
// ----------------------------------------------------------------------------
module current_loop_to_flow_scaler_test;
	import clfs_pkg::*;

	localparam int unsigned ITEM_TARGET = 850;   // samples before the stimulus stops
	localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no handshake at all
	localparam int unsigned HOLD_AT     = 80;    // samples seen before the long hold-off
	localparam int unsigned HOLD_LEN    = 80;    // cycles of the long hold-off
	localparam int unsigned CALM_FROM   = 400;   // window with no idling on either side
	localparam int unsigned CALM_TO     = 560;
	localparam int unsigned IDLE_PCT    = 16;
	localparam int unsigned TAIL_CYCLES = 20;    // extra wait after the last result

	// arithmetic constants of the scaling
	localparam logic [31:0] PCT_FULL   = 32'd10000;
	localparam logic [31:0] PERIOD_DIV = 32'd3600;
	localparam logic [31:0] GAIN_0_20  = 32'd50;
	localparam logic [31:0] GAIN_4_20  = 32'd625;
	localparam logic [31:0] TENTHS     = 32'd10;
	localparam logic [31:0] HI_MULT    = 32'd10000;
	localparam logic [31:0] LO_MULT    = 32'd1000;
	localparam logic [31:0] FLOW_MAX   = 32'd65535;
	localparam logic [31:0] CUR_MAX    = 32'd1023;

	// ------------------------------------------------------------------------
	// scoreboard: local copy of the settings, predictor and pending results
	// ------------------------------------------------------------------------
	class flow_scoreboard;
		cfg_t        cfg;
		res_t        pending[$];
		int unsigned failures;
		int unsigned checked;
		int unsigned pauses;
		int unsigned faults;
		int unsigned per_mode[4];

		function new();
			cfg.mode    = MODE_PCT_4_20;
			cfg.lo_cur  = CUR_W'(40);
			cfg.lo_flow = '0;
			cfg.hi_cur  = CUR_W'(200);
			cfg.hi_flow = '0;
			cfg.rated   = '0;
		endfunction

		function void write_setting(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_MODE:    cfg.mode    = mode_t'(val[1:0]);
				REG_LO_CUR:  cfg.lo_cur  = val[CUR_W-1:0];
				REG_LO_FLOW: cfg.lo_flow = val[FLOW_W-1:0];
				REG_HI_CUR:  cfg.hi_cur  = val[CUR_W-1:0];
				REG_HI_FLOW: cfg.hi_flow = val[FLOW_W-1:0];
				REG_RATED:   cfg.rated   = val[FLOW_W-1:0];
				default: ;
			endcase
		endfunction

		// rounded share of the flow span for a current between the points
		function logic [31:0] interp_step(logic [31:0] c, logic [31:0] i1, logic [31:0] i2,
				logic [31:0] dq);
			logic [31:0] den;
			logic [31:0] num;
			den = i2 - i1;
			num = (c - i1) * (dq * TENTHS);
			return (num + den / 2) / den;
		endfunction

		function res_t scale_current(logic [CUR_W-1:0] cur);
			res_t        r;
			logic [31:0] c, pct, tgt, per;
			logic [31:0] i1, i2, q1, q2;
			r   = '0;
			c   = 32'(cur);
			pct = '0;
			tgt = '0;
			i1  = 32'(cfg.lo_cur);
			i2  = 32'(cfg.hi_cur);
			q1  = 32'(cfg.lo_flow);
			q2  = 32'(cfg.hi_flow);
			case (cfg.mode)
				MODE_PCT_0_20, MODE_PCT_4_20: begin
					if (c > CURRENT_FULL_SCALE) c = CURRENT_FULL_SCALE;
					if (cfg.mode == MODE_PCT_0_20) begin
						pct = c * GAIN_0_20;
					end else begin
						if (c < 32'(LIVE_ZERO_CUR)) c = 32'(LIVE_ZERO_CUR);
						pct = ((c - 32'(LIVE_ZERO_CUR)) * GAIN_4_20) / TENTHS;
					end
					if (pct > PCT_FULL) pct = PCT_FULL;
					tgt       = pct * 32'(cfg.rated);
					per       = tgt / PERIOD_DIV;
					r.pct     = pct[PCT_W-1:0];
					r.period  = per[PER_W-1:0];
					r.per_vld = 1'b1;
					r.pause   = (pct == 0);
				end
				MODE_RISE: begin
					if (i2 <= i1 || q2 < q1) begin
						r.fault = 1'b1;
						r.pause = 1'b1;
					end else if (c < i1 || (c == 0 && i1 == 0 && q1 == 0)) begin
						r.pause = 1'b1;
					end else if (c >= i2) begin
						tgt = q2 * HI_MULT;
					end else begin
						tgt = (q1 * TENTHS + interp_step(c, i1, i2, q2 - q1)) * LO_MULT;
					end
				end
				default: begin
					if (i2 <= i1 || q1 < q2) begin
						r.fault = 1'b1;
					end else if (c >= i2) begin
						tgt = q2 * HI_MULT;
					end else if (c >= i1) begin
						tgt = (q1 * TENTHS - interp_step(c, i1, i2, q1 - q2)) * LO_MULT;
					end
					r.pause = (tgt == 0);
				end
			endcase
			r.target = tgt[TGT_W-1:0];
			return r;
		endfunction

		function void note_sample(logic [CUR_W-1:0] cur);
			res_t r;
			r = scale_current(cur);
			pending.push_back(r);
			per_mode[cfg.mode]++;
			if (r.pause) pauses++;
			if (r.fault) faults++;
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$error("result word with no sample pending: %h", got);
				failures++;
			end else begin
				want = pending.pop_front();
				checked++;
				compare_field("percent", 32'(want.pct), 32'(got.pct));
				compare_field("target_flow", 32'(want.target), 32'(got.target));
				compare_field("period_flow", 32'(want.period), 32'(got.period));
				compare_field("period_flow_valid", 32'(want.per_vld), 32'(got.per_vld));
				compare_field("pause", 32'(want.pause), 32'(got.pause));
				compare_field("calibration_fault", 32'(want.fault), 32'(got.fault));
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// block ports, every input driven to a known value from time zero
	// ------------------------------------------------------------------------
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // [9:0] loop_current
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [13:0] percent, [43:14] target_flow, [61:44] period_flow,
	// [62] period_flow_valid, [63] pause, [64] calibration_fault
	logic [71:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	flow_scoreboard sb = new();

	int unsigned sent;              // samples accepted, stimulus side
	int unsigned settings_loaded;
	int unsigned burst[$];          // currents of one directed group

	current_loop_to_flow_scaler DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// drivers; every task starts and ends just after a rising edge
	// ------------------------------------------------------------------------

	// apb write: setup cycle, access cycle until pready, then idle
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		sb.write_setting(idx, val);
	endtask

	// all six registers, only called with the pipeline empty
	task automatic load_settings(input mode_t m, input logic [31:0] i1, input logic [31:0] q1,
			input logic [31:0] i2, input logic [31:0] q2, input logic [31:0] rated);
		apb_write(REG_MODE, 32'(m));
		apb_write(REG_LO_CUR, i1);
		apb_write(REG_LO_FLOW, q1);
		apb_write(REG_HI_CUR, i2);
		apb_write(REG_HI_FLOW, q2);
		apb_write(REG_RATED, rated);
		settings_loaded++;
	endtask

	// one sample word, with random gaps ahead of it outside the calm window
	task automatic send_current(input logic [CUR_W-1:0] cur);
		while (!(sent >= CALM_FROM && sent < CALM_TO) && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= 16'(cur);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(cur);
		sent++;
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic end_burst();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic send_burst();
		foreach (burst[k]) send_current(CUR_W'(burst[k]));
		end_burst();
	endtask

	// flow setting biased toward the extremes
	function automatic logic [31:0] pick_flow();
		case ($urandom_range(7))
			0:       return 32'd0;
			1:       return FLOW_MAX;
			2:       return $urandom_range(100);
			default: return $urandom_range(65535);
		endcase
	endfunction

	task automatic load_random_settings();
		mode_t       m;
		logic [31:0] i1, i2, qa, qb, q1, q2, tmp;
		m  = mode_t'($urandom_range(3));
		i1 = $urandom_range(900);
		i2 = i1 + $urandom_range(1, CUR_MAX - i1);
		qa = pick_flow();
		qb = pick_flow();
		if (qa > qb) begin
			tmp = qa;
			qa  = qb;
			qb  = tmp;
		end
		// rising wants low flow first, falling the other way round
		if (m == MODE_FALL) begin
			q1 = qb;
			q2 = qa;
		end else begin
			q1 = qa;
			q2 = qb;
		end
		// now and then a broken calibration
		if ($urandom_range(7) == 0) begin
			tmp = q1;
			q1  = q2;
			q2  = tmp;
		end
		if ($urandom_range(9) == 0) begin
			i1 = $urandom_range(1023);
			i2 = $urandom_range(i1);
		end
		load_settings(m, i1, q1, i2, q2, pick_flow());
	endtask

	// currents mostly around the interesting range of the active mode
	function automatic logic [CUR_W-1:0] pick_current();
		int unsigned roll;
		int unsigned lo;
		int unsigned hi;
		roll = $urandom_range(99);
		if (roll < 15) return CUR_W'($urandom_range(1023));
		if (sb.cfg.mode == MODE_PCT_0_20 || sb.cfg.mode == MODE_PCT_4_20)
			return CUR_W'($urandom_range(230));
		lo = (sb.cfg.lo_cur > 8) ? sb.cfg.lo_cur - 8 : 0;
		hi = (sb.cfg.hi_cur < 1015) ? sb.cfg.hi_cur + 8 : 1023;
		if (roll < 25) return (roll < 20) ? CUR_W'(sb.cfg.lo_cur) : CUR_W'(sb.cfg.hi_cur);
		return CUR_W'($urandom_range(lo, hi));
	endfunction

	// ------------------------------------------------------------------------
	// result side: checks every taken word and paces m_tready
	// ------------------------------------------------------------------------
	initial begin : result_side
		int unsigned taken;
		int unsigned samples_seen;
		int unsigned hold_left;
		bit          hold_done;
		bit          ready_next;
		taken        = 0;
		samples_seen = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		forever begin
			@(posedge clk);
			if (s_tvalid && s_tready) samples_seen++;
			if (m_tvalid && m_tready) begin
				sb.check_result(res_t'(m_tdata[$bits(res_t)-1:0]));
				taken++;
			end
			if (hold_left != 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (!hold_done && samples_seen >= HOLD_AT) begin
				// long hold-off while samples keep coming, pipeline fills up
				hold_done  = 1'b1;
				hold_left  = HOLD_LEN - 1;
				ready_next = 1'b0;
			end else if (taken >= CALM_FROM && taken < CALM_TO) begin
				ready_next = 1'b1;
			end else begin
				ready_next = ($urandom_range(99) >= IDLE_PCT);
			end
			m_tready <= ready_next;
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any handshake ends the run
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: %0d cycles without a handshake", QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned n;
		bit          first_random;
		sent            = 0;
		settings_loaded = 0;
		first_random    = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings straight out of reset: 4-20 mA with zero rated flow
		burst = '{100};
		send_burst();

		// 0-20 mA, full rated flow: zero, full scale, above full scale
		load_settings(MODE_PCT_0_20, 0, 0, 1023, 0, FLOW_MAX);
		burst = '{0, 200, 201, 1023};
		send_burst();

		// 4-20 mA: below, at and just above live zero, full scale and beyond
		load_settings(MODE_PCT_4_20, 40, 0, 200, 0, 12345);
		burst = '{39, 40, 41, 200, 1023};
		send_burst();

		// rising: below the low point, on it, between, on the high point
		load_settings(MODE_RISE, 100, 1000, 300, 9000, 0);
		burst = '{99, 100, 101, 299, 300};
		send_burst();

		// rising over the whole range with zero low point: zero current pauses
		load_settings(MODE_RISE, 0, 0, 1023, FLOW_MAX, 0);
		burst = '{0, 1, 1022};
		send_burst();

		// rising with equal point currents, then with falling flows: fault
		load_settings(MODE_RISE, 500, 10, 500, 20, 0);
		burst = '{600};
		send_burst();
		load_settings(MODE_RISE, 100, 500, 300, 400, 0);
		burst = '{200};
		send_burst();

		// falling down to zero flow: upper point gives zero target and pause
		load_settings(MODE_FALL, 50, FLOW_MAX, 250, 0, 0);
		burst = '{49, 150, 250};
		send_burst();

		// falling with rising flows, then with the high point below the low: fault
		load_settings(MODE_FALL, 50, 10, 250, 20, 0);
		burst = '{100};
		send_burst();
		load_settings(MODE_FALL, 1023, 20, 0, 10, 0);
		burst = '{1023};
		send_burst();

		// random settings, random currents; the first group is long enough
		// for the hold-off on the result side to back up into the input
		while (sent < ITEM_TARGET) begin
			load_random_settings();
			n = first_random ? 140 : $urandom_range(20, 50);
			first_random = 1'b0;
			repeat (n) send_current(pick_current());
			end_burst();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d samples under %0d settings, per mode %0d/%0d/%0d/%0d",
			sent, settings_loaded, sb.per_mode[0], sb.per_mode[1], sb.per_mode[2],
			sb.per_mode[3]);
		$display("%0d results checked, %0d with pause, %0d with calibration fault",
			sb.checked, sb.pauses, sb.faults);
		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/clfs_pkg.sv
rtl/clfs_regs.sv
rtl/clfs_front.sv
rtl/clfs_div_stage.sv
rtl/clfs_back.sv
rtl/current_loop_to_flow_scaler.sv
tb/current_loop_to_flow_scaler_test.sv
